### rtl/bac_pkg.sv
// Package for the BCD alarm clock: command and event codes, field widths and constants.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package bac_pkg;

  localparam int unsigned TPS_W     = 20;
  localparam int unsigned TIME_W    = 22;
  localparam int unsigned ALARM_W   = 14;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned SNOOZE_W  = 8;
  localparam int unsigned EVT_W     = 2;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;

  localparam logic [TPS_W-1:0] TPS_RESET = 20'd1000;

  // Register index of ticks_per_second, taken from the word part of the byte address.
  localparam logic REG_TPS = 1'b0;

  localparam logic [11:0] MIN_PER_DAY     = 12'd1440;
  localparam logic [11:0] TWO_DAYS_MIN    = 12'd2880;
  localparam logic [11:0] MIN_PER_10H     = 12'd600;
  localparam logic [11:0] MIN_PER_HOUR    = 12'd60;
  localparam logic [20:0] RECIP_60        = 21'd1093;  // ceil(2^16 / 60)
  localparam int unsigned RECIP_SHIFT     = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_SET_TIME   = 3'd1,
    CMD_SET_ALARM  = 3'd2,
    CMD_ALARM_OFF  = 3'd3,
    CMD_SNOOZE     = 3'd4
  } cmd_e;

  typedef enum logic [EVT_W-1:0] {
    EVT_NONE   = 2'd0,
    EVT_RING   = 2'd1,
    EVT_SNOOZE = 2'd2
  } evt_e;

endpackage

### rtl/bac_cmd_if.sv
// Command channel of the BCD alarm clock: valid/ready handshake and the command payload.
// Depends on bac_pkg for the field widths.
`timescale 1ns / 1ps

interface bac_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [bac_pkg::CMD_W-1:0]      command;
  logic [bac_pkg::TIME_W-1:0]     new_time_bcd;
  logic [bac_pkg::ALARM_W-1:0]    new_alarm_bcd;
  logic [bac_pkg::SNOOZE_W-1:0]   snooze_minutes;

  modport source (
    output valid, command, new_time_bcd, new_alarm_bcd, snooze_minutes,
    input  ready
  );

  modport sink (
    input  valid, command, new_time_bcd, new_alarm_bcd, snooze_minutes,
    output ready
  );
endinterface

### rtl/bac_res_if.sv
// Result channel of the BCD alarm clock: valid/ready handshake and the clock status payload.
// Depends on bac_pkg for the field widths.
`timescale 1ns / 1ps

interface bac_res_if;
  logic                          valid;
  logic                          ready;
  logic [bac_pkg::TIME_W-1:0]    time_bcd;
  logic [bac_pkg::ALARM_W-1:0]   alarm_bcd;
  logic                          time_valid;
  logic                          alarm_enabled;
  logic [bac_pkg::EVT_W-1:0]     alarm_event;

  modport source (
    output valid, time_bcd, alarm_bcd, time_valid, alarm_enabled, alarm_event,
    input  ready
  );

  modport sink (
    input  valid, time_bcd, alarm_bcd, time_valid, alarm_enabled, alarm_event,
    output ready
  );
endinterface

### rtl/bcd_alarm_clock_top.sv
// BCD alarm clock top level: 24-hour clock with prescaler, alarm and snooze.
// A command passes through the input register and then the state registers on its way to the result.
// Throughput: one command per cycle; a command is taken every cycle the result side keeps up.
// Reset (rst_ni low, asynchronous): time 00:00:00 not set, alarm 00:00 disarmed, prescaler 0,
// ticks_per_second 1000, both pipeline slots empty. Depends on bac_pkg, bac_cmd_if, bac_res_if,
// bac_cfg_regs, bac_sec_adv and bac_snooze.
`timescale 1ns / 1ps

module bcd_alarm_clock_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bac_cmd_if.sink                       cmd_i,
  bac_res_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bac_pkg::APB_AW-1:0]    paddr,
  input  logic [bac_pkg::APB_DW-1:0]    pwdata,
  output logic [bac_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  // Configuration register.
  logic [bac_pkg::TPS_W-1:0] tps;

  bac_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tps_o   (tps)
  );

  // Input register. It holds one accepted command until the state stage takes it.
  logic                            in_vld_q, in_vld_d;
  logic [bac_pkg::CMD_W-1:0]       cmd_q;
  logic [bac_pkg::TIME_W-1:0]      new_time_q;
  logic [bac_pkg::ALARM_W-1:0]     new_alarm_q;
  logic [bac_pkg::SNOOZE_W-1:0]    snz_q;

  // Clock state. While a result waits, no command is executed, so the state registers
  // double as the result payload and only the event code needs a register of its own.
  logic [bac_pkg::TIME_W-1:0]      time_q, time_d;
  logic [bac_pkg::ALARM_W-1:0]     alarm_q, alarm_d;
  logic                            time_set_q, time_set_d;
  logic                            armed_q, armed_d;
  logic [bac_pkg::TPS_W-1:0]       tick_q, tick_d;
  logic [bac_pkg::EVT_W-1:0]       evt_q, evt_d;
  logic                            out_vld_q, out_vld_d;

  logic                            exec;
  logic                            in_xfer;
  logic                            sec_due;
  logic [bac_pkg::TPS_W:0]         tick_inc;
  logic [bac_pkg::TIME_W-1:0]      time_adv;
  logic [bac_pkg::ALARM_W-1:0]     alarm_snz;

  // A command executes when the result slot is empty or its result is being taken now.
  // The input side is ready whenever its slot is empty or is being emptied this cycle,
  // which lets a new transfer land while an older result is still on the output.
  assign exec        = in_vld_q && (!out_vld_q || res_o.ready);
  assign cmd_i.ready = !in_vld_q || exec;
  assign in_xfer     = cmd_i.valid && cmd_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (exec) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q       <= cmd_i.command;
      new_time_q  <= cmd_i.new_time_bcd;
      new_alarm_q <= cmd_i.new_alarm_bcd;
      snz_q       <= cmd_i.snooze_minutes;
    end
  end

  // Datapath units.
  bac_sec_adv u_sec_adv (
    .time_i (time_q),
    .time_o (time_adv)
  );

  bac_snooze u_snooze (
    .alarm_i   (alarm_q),
    .minutes_i (snz_q),
    .alarm_o   (alarm_snz)
  );

  // Prescaler: a second is due once the incremented count reaches ticks_per_second.
  // A zero setting compares like one, so then every tick advances the time.
  assign tick_inc = {1'b0, tick_q} + {{bac_pkg::TPS_W{1'b0}}, 1'b1};
  assign sec_due  = tick_inc >= {1'b0, tps};

  always_comb begin
    time_d     = time_q;
    alarm_d    = alarm_q;
    time_set_d = time_set_q;
    armed_d    = armed_q;
    tick_d     = tick_q;
    evt_d      = evt_q;
    out_vld_d  = out_vld_q;

    if (res_o.ready) begin
      out_vld_d = 1'b0;
    end

    if (exec) begin
      out_vld_d = 1'b1;
      evt_d     = bac_pkg::EVT_NONE;
      unique case (bac_pkg::cmd_e'(cmd_q))
        bac_pkg::CMD_TICK: begin
          if (sec_due) begin
            time_d = time_adv;
            tick_d = '0;
            // The alarm rings on every second of the matching minute.
            if ((time_adv[bac_pkg::TIME_W-1:8] == alarm_q) && time_set_q && armed_q) begin
              evt_d = bac_pkg::EVT_RING;
            end
          end else begin
            tick_d = tick_inc[bac_pkg::TPS_W-1:0];
          end
        end
        bac_pkg::CMD_SET_TIME: begin
          // The prescaler keeps counting across a time load.
          time_d     = new_time_q;
          time_set_d = 1'b1;
        end
        bac_pkg::CMD_SET_ALARM: begin
          alarm_d = new_alarm_q;
          armed_d = 1'b1;
        end
        bac_pkg::CMD_ALARM_OFF: begin
          armed_d = 1'b0;
        end
        bac_pkg::CMD_SNOOZE: begin
          // Snooze moves the alarm even when it is disarmed and leaves arming alone.
          alarm_d = alarm_snz;
          evt_d   = bac_pkg::EVT_SNOOZE;
        end
        default: begin
          // Unused command codes leave the state alone and report no event.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q     <= '0;
      alarm_q    <= '0;
      time_set_q <= 1'b0;
      armed_q    <= 1'b0;
      tick_q     <= '0;
      evt_q      <= bac_pkg::EVT_NONE;
      out_vld_q  <= 1'b0;
    end else begin
      time_q     <= time_d;
      alarm_q    <= alarm_d;
      time_set_q <= time_set_d;
      armed_q    <= armed_d;
      tick_q     <= tick_d;
      evt_q      <= evt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Result channel: one transfer per executed command, showing the state after it.
  assign res_o.valid         = out_vld_q;
  assign res_o.time_bcd      = time_q;
  assign res_o.alarm_bcd     = alarm_q;
  assign res_o.time_valid    = time_set_q;
  assign res_o.alarm_enabled = armed_q;
  assign res_o.alarm_event   = evt_q;

endmodule

### rtl/bac_cfg_regs.sv
// APB-style configuration register file of the BCD alarm clock (ticks_per_second).
// Depends on bac_pkg for widths, the register index and the reset value.
`timescale 1ns / 1ps

module bac_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bac_pkg::APB_AW-1:0]    paddr,
  input  logic [bac_pkg::APB_DW-1:0]    pwdata,
  output logic [bac_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output logic [bac_pkg::TPS_W-1:0]     tps_o
);

  logic [bac_pkg::TPS_W-1:0] tps_q;
  logic [bac_pkg::TPS_W-1:0] tps_d;
  logic                      wr_tps;

  // The low two address bits select a byte within the word and are not decoded.
  assign wr_tps = psel && penable && pwrite && (paddr[2] == bac_pkg::REG_TPS);

  always_comb begin
    tps_d = tps_q;
    if (wr_tps) begin
      tps_d = pwdata[bac_pkg::TPS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= bac_pkg::TPS_RESET;
    end else begin
      tps_q <= tps_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == bac_pkg::REG_TPS) begin
      prdata = {{(bac_pkg::APB_DW - bac_pkg::TPS_W){1'b0}}, tps_q};
    end
  end

  assign pready = 1'b1;
  assign tps_o  = tps_q;

endmodule

### rtl/bac_sec_adv.sv
// One-second advance of a packed BCD HH:MM:SS time with decimal carries and midnight wrap.
// Purely combinational; depends on bac_pkg for the time width.
`timescale 1ns / 1ps

module bac_sec_adv (
  input  logic [bac_pkg::TIME_W-1:0] time_i,
  output logic [bac_pkg::TIME_W-1:0] time_o
);

  logic [3:0] s1, s10, m1, m10, h1;
  logic [1:0] h10;

  always_comb begin
    s1  = time_i[3:0];
    s10 = time_i[7:4];
    m1  = time_i[11:8];
    m10 = time_i[15:12];
    h1  = time_i[19:16];
    h10 = time_i[21:20];

    // A digit at or above its top legal value rolls to zero and carries upward.
    if (s1 < 4'd9) begin
      s1 = s1 + 4'd1;
    end else begin
      s1 = 4'd0;
      if (s10 < 4'd5) begin
        s10 = s10 + 4'd1;
      end else begin
        s10 = 4'd0;
        if (m1 < 4'd9) begin
          m1 = m1 + 4'd1;
        end else begin
          m1 = 4'd0;
          if (m10 < 4'd5) begin
            m10 = m10 + 4'd1;
          end else begin
            m10 = 4'd0;
            // Past 23:59:59 the whole day wraps to midnight.
            if (h10 >= 2'd2 && h1 >= 4'd3) begin
              h1  = 4'd0;
              h10 = 2'd0;
            end else if (h1 >= 4'd9) begin
              h1  = 4'd0;
              h10 = h10 + 2'd1;
            end else begin
              h1 = h1 + 4'd1;
            end
          end
        end
      end
    end

    time_o = {h10, h1, m10, m1, s10, s1};
  end

endmodule

### rtl/bac_snooze.sv
// Snooze arithmetic: adds minutes to a packed BCD HH:MM alarm time modulo one day.
// Purely combinational; depends on bac_pkg for widths and minute constants.
`timescale 1ns / 1ps

module bac_snooze (
  input  logic [bac_pkg::ALARM_W-1:0]  alarm_i,
  input  logic [bac_pkg::SNOOZE_W-1:0] minutes_i,
  output logic [bac_pkg::ALARM_W-1:0]  alarm_o
);

  logic [11:0] total;
  logic [10:0] day_min;
  logic [20:0] prod;
  logic [4:0]  hours;
  logic [5:0]  mins;
  logic [10:0] hour_min;
  logic [1:0]  h10;
  logic [4:0]  h1_w;
  logic [3:0]  m10;
  logic [5:0]  m1_w;

  // Each digit is weighted by its place value, so non-BCD digits still count.
  always_comb begin
    total = 12'(alarm_i[13:12]) * bac_pkg::MIN_PER_10H
          + 12'(alarm_i[11:8])  * bac_pkg::MIN_PER_HOUR
          + 12'(alarm_i[7:4])   * 12'd10
          + 12'(alarm_i[3:0])
          + 12'(minutes_i);
  end

  // The sum stays below three days, so two conditional subtracts finish the modulo.
  always_comb begin
    if (total >= bac_pkg::TWO_DAYS_MIN) begin
      day_min = 11'(total - bac_pkg::TWO_DAYS_MIN);
    end else if (total >= bac_pkg::MIN_PER_DAY) begin
      day_min = 11'(total - bac_pkg::MIN_PER_DAY);
    end else begin
      day_min = 11'(total);
    end
  end

  // Hours by reciprocal multiplication; exact for every value below one day.
  assign prod     = 21'(day_min) * bac_pkg::RECIP_60;
  assign hours    = prod[bac_pkg::RECIP_SHIFT +: 5];
  assign hour_min = 11'(hours) * 11'(bac_pkg::MIN_PER_HOUR);
  assign mins     = 6'(day_min - hour_min);

  always_comb begin
    priority if (hours >= 5'd20) begin
      h10  = 2'd2;
      h1_w = hours - 5'd20;
    end else if (hours >= 5'd10) begin
      h10  = 2'd1;
      h1_w = hours - 5'd10;
    end else begin
      h10  = 2'd0;
      h1_w = hours;
    end
  end

  always_comb begin
    priority if (mins >= 6'd50) begin
      m10  = 4'd5;
      m1_w = mins - 6'd50;
    end else if (mins >= 6'd40) begin
      m10  = 4'd4;
      m1_w = mins - 6'd40;
    end else if (mins >= 6'd30) begin
      m10  = 4'd3;
      m1_w = mins - 6'd30;
    end else if (mins >= 6'd20) begin
      m10  = 4'd2;
      m1_w = mins - 6'd20;
    end else if (mins >= 6'd10) begin
      m10  = 4'd1;
      m1_w = mins - 6'd10;
    end else begin
      m10  = 4'd0;
      m1_w = mins;
    end
  end

  assign alarm_o = {h10, h1_w[3:0], m10, m1_w[3:0]};

endmodule

### dv/testbench.sv
// Self-checking testbench for the BCD alarm clock: directed and random command streams,
// checked against an in-bench clock predictor. Depends on bac_pkg, bac_cmd_if, bac_res_if
// and bcd_alarm_clock_top.
`timescale 1ns / 1ps

module testbench;

  // Codes 5 to 7 have no meaning; the clock must ignore them.
  localparam logic [bac_pkg::CMD_W-1:0]  CMD_UNUSED_LO = 3'd5;
  localparam logic [bac_pkg::CMD_W-1:0]  CMD_UNUSED_HI = 3'd7;
  localparam logic [bac_pkg::APB_AW-1:0] TPS_ADDR      = {bac_pkg::REG_TPS, 2'b00};

  localparam int unsigned MINUTES_PER_DAY = 1440;
  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned HOLD_CYCLES     = 300;  // long result-side stall
  localparam int unsigned PHASE_ITEMS     = 150;
  localparam int unsigned NUM_PHASES      = 8;

  typedef struct {
    logic [bac_pkg::CMD_W-1:0]    command;
    logic [bac_pkg::TIME_W-1:0]   new_time;
    logic [bac_pkg::ALARM_W-1:0]  new_alarm;
    logic [bac_pkg::SNOOZE_W-1:0] snooze;
  } clock_cmd_t;

  typedef struct {
    logic [bac_pkg::TIME_W-1:0]  time_bcd;
    logic [bac_pkg::ALARM_W-1:0] alarm_bcd;
    logic                        time_valid;
    logic                        alarm_enabled;
    logic [bac_pkg::EVT_W-1:0]   alarm_event;
  } clock_status_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [bac_pkg::APB_AW-1:0]   paddr;
  logic [bac_pkg::APB_DW-1:0]   pwdata;
  logic [bac_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  bac_cmd_if cmd_if ();
  bac_res_if res_if ();

  bcd_alarm_clock_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  // Commands waiting to be offered, and the status words the clock owes us.
  clock_cmd_t    pending_cmds[$];
  clock_status_t expected_status[$];

  // Predictor state: a shadow copy of the clock and its prescaler setting.
  logic [bac_pkg::TPS_W-1:0]   tick_rate;
  logic [bac_pkg::TPS_W-1:0]   prescale;
  logic [bac_pkg::TIME_W-1:0]  clock_time;
  logic [bac_pkg::ALARM_W-1:0] alarm_time;
  logic                        time_set;
  logic                        alarm_armed;

  logic        cmd_taken;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_requests;
  int unsigned hold_served  = 0;
  int unsigned hold_left    = 0;
  int unsigned queued_total;
  int unsigned rings_seen   = 0;
  int unsigned snoozes_seen = 0;
  int unsigned fail_count   = 0;

  // ---------------------------------------------------------------------------
  // Clock predictor.
  // ---------------------------------------------------------------------------

  // One second forward with decimal carries. Out-of-range digits fold to zero and
  // carry; an hour of 2x with x of 3 or more wraps the whole day.
  function automatic logic [bac_pkg::TIME_W-1:0] next_second(
      input logic [bac_pkg::TIME_W-1:0] t);
    logic [3:0] s1, s10, m1, m10, h1;
    logic [1:0] h10;
    {h10, h1, m10, m1, s10, s1} = t;
    if (s1 < 4'd9) begin
      s1++;
    end else begin
      s1 = '0;
      if (s10 < 4'd5) begin
        s10++;
      end else begin
        s10 = '0;
        if (m1 < 4'd9) begin
          m1++;
        end else begin
          m1 = '0;
          if (m10 < 4'd5) begin
            m10++;
          end else begin
            m10 = '0;
            if (h10 >= 2'd2 && h1 >= 4'd3) begin
              h1  = '0;
              h10 = '0;
            end else if (h1 >= 4'd9) begin
              h1  = '0;
              h10 = h10 + 2'd1;
            end else begin
              h1++;
            end
          end
        end
      end
    end
    return {h10, h1, m10, m1, s10, s1};
  endfunction

  // Snooze works in plain minutes: each digit counts at its place value, so
  // invalid digits still land on a legal time after the modulo.
  function automatic logic [bac_pkg::ALARM_W-1:0] snoozed_alarm(
      input logic [bac_pkg::ALARM_W-1:0] a, input logic [bac_pkg::SNOOZE_W-1:0] mins);
    int unsigned total, hh, mm;
    logic [bac_pkg::ALARM_W-1:0] r;
    total = 32'(a[13:12]) * 600 + 32'(a[11:8]) * 60 + 32'(a[7:4]) * 10
          + 32'(a[3:0]) + 32'(mins);
    total = total % MINUTES_PER_DAY;
    hh = total / 60;
    mm = total % 60;
    r[13:12] = 2'(hh / 10);
    r[11:8]  = 4'(hh % 10);
    r[7:4]   = 4'(mm / 10);
    r[3:0]   = 4'(mm % 10);
    return r;
  endfunction

  task automatic apply_command(input clock_cmd_t c);
    clock_status_t   st;
    bac_pkg::evt_e   evt;
    evt = bac_pkg::EVT_NONE;
    unique case (c.command)
      bac_pkg::CMD_TICK: begin
        // A rate of zero acts like one, which this comparison gives for free.
        if ({1'b0, prescale} + 21'd1 >= {1'b0, tick_rate}) begin
          clock_time = next_second(clock_time);
          prescale   = '0;
          if (clock_time[bac_pkg::TIME_W-1:8] == alarm_time && time_set && alarm_armed) begin
            evt = bac_pkg::EVT_RING;
          end
        end else begin
          prescale = prescale + bac_pkg::TPS_W'(1);
        end
      end
      bac_pkg::CMD_SET_TIME: begin
        // The prescaler keeps counting across a time load.
        clock_time = c.new_time;
        time_set   = 1'b1;
      end
      bac_pkg::CMD_SET_ALARM: begin
        alarm_time  = c.new_alarm;
        alarm_armed = 1'b1;
      end
      bac_pkg::CMD_ALARM_OFF: begin
        alarm_armed = 1'b0;
      end
      bac_pkg::CMD_SNOOZE: begin
        // Snooze moves the alarm even when it is disarmed, and leaves it disarmed.
        alarm_time = snoozed_alarm(alarm_time, c.snooze);
        evt        = bac_pkg::EVT_SNOOZE;
      end
      default: begin
      end
    endcase
    if (evt == bac_pkg::EVT_RING) rings_seen++;
    if (evt == bac_pkg::EVT_SNOOZE) snoozes_seen++;
    st.time_bcd      = clock_time;
    st.alarm_bcd     = alarm_time;
    st.time_valid    = time_set;
    st.alarm_enabled = alarm_armed;
    st.alarm_event   = evt;
    expected_status.push_back(st);
  endtask

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: checks result transfers against the oldest expectation, then feeds
  // every command transfer to the predictor. A result never belongs to the
  // command taken at the same edge, so this order is safe.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    clock_status_t want;
    clock_cmd_t    seen;
    if (!rst_ni) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= cmd_if.valid && cmd_if.ready;
      if (res_if.valid && res_if.ready) begin
        if (expected_status.size() == 0) begin
          $display("%0t ns: result transfer with nothing expected, time %0h alarm %0h",
                   $time, res_if.time_bcd, res_if.alarm_bcd);
          fail_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("time_bcd", 32'(want.time_bcd), 32'(res_if.time_bcd));
          check_field("alarm_bcd", 32'(want.alarm_bcd), 32'(res_if.alarm_bcd));
          check_field("time_valid", 32'(want.time_valid), 32'(res_if.time_valid));
          check_field("alarm_enabled", 32'(want.alarm_enabled),
                      32'(res_if.alarm_enabled));
          check_field("alarm_event", 32'(want.alarm_event), 32'(res_if.alarm_event));
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        seen.command   = cmd_if.command;
        seen.new_time  = cmd_if.new_time_bcd;
        seen.new_alarm = cmd_if.new_alarm_bcd;
        seen.snooze    = cmd_if.snooze_minutes;
        apply_command(seen);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command driver. The head of the queue leaves once its transfer has been
  // seen; an offered command is held until it is taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cmd_taken) pending_cmds.delete(0);
      if (pending_cmds.size() != 0 &&
          ((cmd_if.valid && !cmd_taken) || $urandom_range(0, 99) >= src_idle_pct)) begin
        cmd_if.valid          <= 1'b1;
        cmd_if.command        <= pending_cmds[0].command;
        cmd_if.new_time_bcd   <= pending_cmds[0].new_time;
        cmd_if.new_alarm_bcd  <= pending_cmds[0].new_alarm;
        cmd_if.snooze_minutes <= pending_cmds[0].snooze;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end else begin
      cmd_if.valid          <= 1'b0;
      cmd_if.command        <= '0;
      cmd_if.new_time_bcd   <= '0;
      cmd_if.new_alarm_bcd  <= '0;
      cmd_if.snooze_minutes <= '0;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] to_bcd2(input int unsigned v);
    logic [7:0] r;
    r[7:4] = 4'(v / 10);
    r[3:0] = 4'(v % 10);
    return r;
  endfunction

  function automatic logic [bac_pkg::TIME_W-1:0] rand_time_field();
    logic [bac_pkg::TIME_W-1:0] raw;
    logic [7:0]                 hh, mm, ss;
    raw = bac_pkg::TIME_W'($urandom());
    hh  = to_bcd2($urandom_range(0, 23));
    mm  = to_bcd2($urandom_range(0, 59));
    ss  = to_bcd2($urandom_range(0, 59));
    // A quarter of the loads carry arbitrary bits, invalid digits included.
    return ($urandom_range(0, 3) == 0) ? raw : {hh[5:0], mm, ss};
  endfunction

  function automatic logic [bac_pkg::ALARM_W-1:0] rand_alarm_field();
    logic [bac_pkg::ALARM_W-1:0] raw;
    logic [7:0]                  hh, mm;
    raw = bac_pkg::ALARM_W'($urandom());
    hh  = to_bcd2($urandom_range(0, 23));
    mm  = to_bcd2($urandom_range(0, 59));
    return ($urandom_range(0, 3) == 0) ? raw : {hh[5:0], mm};
  endfunction

  task automatic queue_cmd(input logic [bac_pkg::CMD_W-1:0] c,
                           input logic [bac_pkg::TIME_W-1:0] t,
                           input logic [bac_pkg::ALARM_W-1:0] a,
                           input logic [bac_pkg::SNOOZE_W-1:0] m);
    clock_cmd_t item;
    item.command   = c;
    item.new_time  = t;
    item.new_alarm = a;
    item.snooze    = m;
    pending_cmds.push_back(item);
    queued_total++;
  endtask

  // Unrelated fields carry random bits so that the clock is seen to ignore them.
  task automatic queue_random(input logic [bac_pkg::CMD_W-1:0] c);
    queue_cmd(c, rand_time_field(), rand_alarm_field(),
              bac_pkg::SNOOZE_W'($urandom_range(0, 255)));
  endtask

  task automatic queue_random_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45)      queue_random(bac_pkg::CMD_TICK);
    else if (r < 57) queue_random(bac_pkg::CMD_SET_TIME);
    else if (r < 69) queue_random(bac_pkg::CMD_SET_ALARM);
    else if (r < 76) queue_random(bac_pkg::CMD_ALARM_OFF);
    else if (r < 92) queue_random(bac_pkg::CMD_SNOOZE);
    else queue_random(bac_pkg::CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)));
  endtask

  // Arm an alarm, put the clock just short of (or inside) that minute, then tick.
  // Some runs start near midnight so the day wrap meets the alarm.
  task automatic queue_alarm_run();
    logic [bac_pkg::ALARM_W-1:0] al;
    logic [7:0]                  sec;
    int unsigned                 r;
    al  = ($urandom_range(0, 4) == 0) ? 14'h0000 : rand_alarm_field();
    sec = to_bcd2($urandom_range(45, 59));
    queue_cmd(bac_pkg::CMD_SET_ALARM, rand_time_field(), al,
              bac_pkg::SNOOZE_W'($urandom_range(0, 255)));
    if (al == 14'h0000 && $urandom_range(0, 1) == 0) begin
      queue_cmd(bac_pkg::CMD_SET_TIME, {14'h2359, sec}, rand_alarm_field(),
                bac_pkg::SNOOZE_W'($urandom_range(0, 255)));
    end else begin
      queue_cmd(bac_pkg::CMD_SET_TIME, {al, sec}, rand_alarm_field(),
                bac_pkg::SNOOZE_W'($urandom_range(0, 255)));
    end
    repeat ($urandom_range(4, 40)) begin
      r = $urandom_range(0, 99);
      if (r < 4)      queue_random(bac_pkg::CMD_SNOOZE);
      else if (r < 7) queue_random(bac_pkg::CMD_ALARM_OFF);
      else if (r < 9)
        queue_random(bac_pkg::CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)));
      else            queue_random(bac_pkg::CMD_TICK);
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || expected_status.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write and read-back; only called while the clock is idle.
  task automatic write_rate(input int unsigned rate);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TPS_ADDR;
    pwdata  <= rate;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tick_rate = bac_pkg::TPS_W'(rate);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    check_field("ticks_per_second read-back",
                {{(bac_pkg::APB_DW-bac_pkg::TPS_W){1'b0}}, tick_rate}, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned rate_plan[NUM_PHASES];
    int unsigned phase_goal;

    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    src_idle_pct          = 35;
    sink_stall_pct        = 35;
    hold_requests         = 0;
    queued_total          = 0;

    // Predictor starts from the reset state of the clock.
    tick_rate   = bac_pkg::TPS_RESET;
    prescale    = '0;
    clock_time  = '0;
    alarm_time  = '0;
    time_set    = 1'b0;
    alarm_armed = 1'b0;

    // Random phases: the zero rate, small rates, a slow rate and a far slower one.
    rate_plan = '{0, 2, 1, 3, 7, 1000000, 60, 1};

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default rate: ticks only feed the prescaler. The clock is not set yet, so
    // nothing may ring; snooze still moves a disarmed alarm; unused codes do nothing.
    queue_cmd(bac_pkg::CMD_TICK, '0, '0, '0);
    queue_cmd(bac_pkg::CMD_SNOOZE, '1, '1, '0);
    queue_cmd(CMD_UNUSED_LO, '1, '1, '1);
    queue_cmd(CMD_UNUSED_LO + 3'd1, '1, '1, '1);
    queue_cmd(CMD_UNUSED_HI, '1, '1, '1);
    queue_cmd(bac_pkg::CMD_ALARM_OFF, '1, '1, '1);
    wait_drained();

    // One tick per second from here on for the directed cases.
    write_rate(1);
    queue_cmd(bac_pkg::CMD_SET_TIME, 22'h235958, '0, '0);
    queue_cmd(bac_pkg::CMD_SET_ALARM, '0, 14'h0000, '0);
    queue_cmd(bac_pkg::CMD_TICK, '0, '0, '0);          // 23:59:59
    queue_cmd(bac_pkg::CMD_TICK, '0, '0, '0);          // day wrap into the alarm minute
    queue_cmd(bac_pkg::CMD_TICK, '0, '0, '0);          // rings again in the same minute
    queue_cmd(bac_pkg::CMD_ALARM_OFF, '0, '0, '0);
    queue_cmd(bac_pkg::CMD_TICK, '0, '0, '0);          // disarmed, silent
    queue_cmd(bac_pkg::CMD_SET_ALARM, '0, 14'h0000, '0);
    queue_cmd(bac_pkg::CMD_SNOOZE, '0, '0, 8'hFF);     // largest snooze
    queue_cmd(bac_pkg::CMD_SNOOZE, '0, '0, 8'h00);     // zero snooze still reports
    queue_cmd(bac_pkg::CMD_SET_ALARM, '0, '1, '0);     // all-ones alarm digits
    queue_cmd(bac_pkg::CMD_SNOOZE, '0, '0, 8'h01);     // snooze folds invalid digits
    queue_cmd(bac_pkg::CMD_SET_TIME, '1, '0, '0);      // all-ones time digits
    queue_cmd(bac_pkg::CMD_TICK, '0, '0, '0);
    queue_cmd(bac_pkg::CMD_SET_TIME, 22'h195959, '0, '0);
    queue_cmd(bac_pkg::CMD_TICK, '0, '0, '0);          // hour units carry into tens
    queue_cmd(bac_pkg::CMD_SET_TIME, 22'h095959, '0, '0);
    queue_cmd(bac_pkg::CMD_TICK, '0, '0, '0);
    queue_cmd(bac_pkg::CMD_SET_TIME, 22'h225959, '0, '0);
    queue_cmd(bac_pkg::CMD_SET_ALARM, '0, 14'h2300, '0);
    queue_cmd(bac_pkg::CMD_TICK, '0, '0, '0);          // rings at 23:00:00
    queue_cmd(bac_pkg::CMD_SET_TIME, 22'h000000, '0, '0);
    wait_drained();

    // Random phases. One phase runs without any idling; another holds off the
    // result side for a long stretch while commands keep coming.
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      write_rate(rate_plan[ph]);
      src_idle_pct   = (ph == 2 || ph == 4) ? 0 : 35;
      sink_stall_pct = (ph == 2) ? 0 : 35;
      phase_goal = queued_total + PHASE_ITEMS;
      while (queued_total < phase_goal) begin
        if ($urandom_range(0, 99) < 40) queue_alarm_run();
        else queue_random_cmd();
      end
      if (ph == 4) hold_requests++;
      wait_drained();
    end

    $display("Covered %0d commands over %0d rate phases, including a zero and the top rate.",
             queued_total, NUM_PHASES + 2);
    $display("The predictor saw %0d alarm rings and %0d snoozes.", rings_seen, snoozes_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legitimate run.
  initial begin
    #2000000;
    $display("Timeout with %0d commands pending and %0d results outstanding.",
             pending_cmds.size(), expected_status.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
